/* hdl/pwrv_pkg.sv */
// shared constants, types and register indexes for the power rail vote aggregator
package pwrv_pkg;

   localparam int NUM_CHIPS   = 3;
   localparam int NUM_RAILS   = 12;
   localparam int NUM_SOURCES = 8;

   localparam int PAIRS      = NUM_CHIPS * NUM_RAILS;
   localparam int VOLT_DEPTH = PAIRS * NUM_SOURCES;

   localparam int SRC_W   = 4;
   localparam int CHIP_W  = 2;
   localparam int RAIL_W  = 4;
   localparam int VOLT_W  = 24;
   localparam int COUNT_W = 8;
   localparam int CSRC_W  = 3;

   localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int VADDR_W = (VOLT_DEPTH > 1) ? $clog2(VOLT_DEPTH) : 1;
   localparam int SIDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VOTE_RAIL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNTED_SOURCE = 1'b1;

   typedef struct packed {
      logic [NUM_SOURCES-1:0] mask;
      logic [COUNT_W-1:0]     count;
   } pair_entry_type;

   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [CHIP_W-1:0] chip;
      logic [RAIL_W-1:0] rail;
      logic              want_on;
      logic [VOLT_W-1:0] volt_req;
   } req_payload_type;

   typedef struct packed {
      logic              status;
      logic              rail_on;
      logic [VOLT_W-1:0] volt_out;
      logic [CHIP_W-1:0] chip_out;
      logic [RAIL_W-1:0] rail_out;
   } rsp_payload_type;

endpackage

/* hdl/pwrv_req_if.sv */
// request channel: valid/ready handshake with the request payload
interface pwrv_req_if import pwrv_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/pwrv_rsp_if.sv */
// response channel: valid/ready handshake with the result payload
interface pwrv_rsp_if import pwrv_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/pwrv_ram.sv */
// generic single-port ram with registered read
module pwrv_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/power_rail_vote_aggregator_unit.sv */
// top level of the power rail vote aggregator: per-rail vote memories and result logic
//
//   channel   dir   handshake              carries
//   req_chan  in    valid/ready transfer   source, chip, rail, want_on, volt_req
//   rsp_chan  out   valid/ready transfer   status, rail_on, volt_out, chip_out, rail_out
//   csr_*     in    csr_we, no back-press  max_vote_rail (index 0), counted_source (index 1)
//
// one request at a time: a rejected request goes accept then result, an ordinary one
// accept, update, result, and a max-vote request with other voters adds a scan, one
// read per source through the single port of the voltage memory, and a drain
// reset is synchronous and active high; it clears the per-pair valid bits, so the
// mask/count memory reads as zero until written, with no clearing pass
// a stalled response holds in the output register; the next request is taken only
// once that result has moved into it
module power_rail_vote_aggregator_unit import pwrv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pwrv_req_if.sink              req_chan,
   pwrv_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [RAIL_W-1:0] max_vote_rail_ff;
   logic [CSRC_W-1:0] counted_source_ff;

   // request held for the whole operation
   logic [SIDX_W-1:0]      src_ff;
   logic [CHIP_W-1:0]      chip_ff;
   logic [RAIL_W-1:0]      rail_ff;
   logic                   on_ff;
   logic [VOLT_W-1:0]      volt_ff;
   logic [PAIR_W-1:0]      pair_ff;
   logic                   bad_ff;
   logic                   rail_on_ff;
   logic [NUM_SOURCES-1:0] mask_ff;

   // max-vote scan
   logic [SIDX_W-1:0] scan_cnt_ff;
   logic [SIDX_W-1:0] rd_idx_ff;
   logic              rd_pend_ff;
   logic [VOLT_W-1:0] best_ff;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   // per-pair valid bits, an unwritten pair reads as all zero
   logic [PAIRS-1:0] pair_valid_ff;

   logic           req_fire;
   logic           req_bad;
   logic [PAIR_W-1:0] req_pair;

   logic              pair_we;
   logic [PAIR_W-1:0] pair_addr;
   pair_entry_type    pair_rdata;
   pair_entry_type    pair_old;
   pair_entry_type    pair_new;

   logic               volt_we;
   logic [VADDR_W-1:0] volt_addr;
   logic [VOLT_W-1:0]  volt_wdata;
   logic [VOLT_W-1:0]  volt_rdata;
   logic [SIDX_W-1:0]  volt_idx;

   logic [NUM_SOURCES-1:0] req_bit;
   logic                   is_counted;
   logic                   volt_touch;
   logic                   use_max;
   logic [VOLT_W-1:0]      cand;
   logic                   emit_go;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_bad = (int'(req_chan.payload.source) >= NUM_SOURCES) ||
                    (int'(req_chan.payload.chip) >= NUM_CHIPS) ||
                    (int'(req_chan.payload.rail) >= NUM_RAILS);

   assign req_pair = PAIR_W'(int'(req_chan.payload.chip) * NUM_RAILS +
                             int'(req_chan.payload.rail));

   // mask/count memory is read straight from the request so data is ready in update
   assign pair_addr = (state_ff == ST_IDLE) ? req_pair : pair_ff;
   assign pair_we   = (state_ff == ST_UPDATE);

   pwrv_ram #(
      .WIDTH ($bits(pair_entry_type)),
      .DEPTH (PAIRS)
   ) u_pair_ram (
      .clock (clock),
      .we    (pair_we),
      .addr  (pair_addr),
      .wdata (pair_new),
      .rdata (pair_rdata)
   );

   assign pair_old   = pair_valid_ff[pair_ff] ? pair_rdata : '0;
   assign req_bit    = NUM_SOURCES'(1) << src_ff;
   assign is_counted = (int'(src_ff) == int'(counted_source_ff));

   // read-modify-write of the pair entry and the requester's stored voltage
   always_comb begin
      pair_new   = pair_old;
      volt_touch = 1'b1;
      if (is_counted) begin
         if (on_ff) begin
            pair_new.mask = pair_old.mask | req_bit;
            if (pair_old.count != COUNT_MAX) begin
               pair_new.count = pair_old.count + COUNT_W'(1);
            end
         end else if (pair_old.count != '0) begin
            pair_new.count = pair_old.count - COUNT_W'(1);
         end
         if (pair_new.count == '0) begin
            pair_new.mask = pair_new.mask & ~req_bit;
         end else if (!on_ff) begin
            // still referenced: stored voltage stays as it is
            volt_touch = 1'b0;
         end
      end else if (on_ff) begin
         pair_new.mask = pair_old.mask | req_bit;
      end else begin
         pair_new.mask = pair_old.mask & ~req_bit;
      end
      if (pair_new.mask == '0) begin
         volt_touch = 1'b1;
      end
   end

   assign use_max = ((pair_new.mask & ~req_bit) != '0) && (rail_ff == max_vote_rail_ff);

   // voltage memory: requester write in update, one source read per scan cycle
   assign volt_idx   = (state_ff == ST_SCAN) ? scan_cnt_ff : src_ff;
   assign volt_addr  = VADDR_W'(int'(pair_ff) * NUM_SOURCES + int'(volt_idx));
   assign volt_we    = (state_ff == ST_UPDATE) && volt_touch;
   assign volt_wdata = on_ff ? volt_ff : '0;

   pwrv_ram #(
      .WIDTH (VOLT_W),
      .DEPTH (VOLT_DEPTH)
   ) u_volt_ram (
      .clock (clock),
      .we    (volt_we),
      .addr  (volt_addr),
      .wdata (volt_wdata),
      .rdata (volt_rdata)
   );

   // a source without its mask bit has a cleared (or never written) entry
   assign cand = mask_ff[rd_idx_ff] ? volt_rdata : '0;

   assign emit_go = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_bad ? ST_EMIT : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = use_max ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == SIDX_W'(NUM_SOURCES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         max_vote_rail_ff  <= '0;
         counted_source_ff <= '0;
         pair_valid_ff     <= '0;
         rd_pend_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_MAX_VOTE_RAIL: begin
                  max_vote_rail_ff <= csr_wdata[RAIL_W-1:0];
               end
               REG_COUNTED_SOURCE: begin
                  counted_source_ff <= csr_wdata[CSRC_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (pair_we) begin
            pair_valid_ff[pair_ff] <= 1'b1;
         end
         rd_pend_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         src_ff     <= req_chan.payload.source[SIDX_W-1:0];
         chip_ff    <= req_chan.payload.chip;
         rail_ff    <= req_chan.payload.rail;
         on_ff      <= req_chan.payload.want_on;
         volt_ff    <= req_chan.payload.volt_req;
         pair_ff    <= req_pair;
         bad_ff     <= req_bad;
         rail_on_ff <= 1'b0;
         best_ff    <= '0;
      end
      if (state_ff == ST_UPDATE) begin
         mask_ff     <= pair_new.mask;
         rail_on_ff  <= (pair_new.mask != '0);
         scan_cnt_ff <= '0;
         best_ff     <= use_max ? '0 : volt_ff;
      end
      if (state_ff == ST_SCAN) begin
         rd_idx_ff   <= scan_cnt_ff;
         scan_cnt_ff <= scan_cnt_ff + SIDX_W'(1);
      end
      if (rd_pend_ff && (cand > best_ff)) begin
         best_ff <= cand;
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_ff.status   <= bad_ff;
         rsp_ff.rail_on  <= rail_on_ff;
         rsp_ff.volt_out <= best_ff;
         rsp_ff.chip_out <= chip_ff;
         rsp_ff.rail_out <= rail_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // a rejected request reports an off rail at zero volts
   a_bad_result_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status) |->
         (!rsp_chan.payload.rail_on && (rsp_chan.payload.volt_out == '0)))
      else $error("rejected request with non-zero result");

   // a rejected request skips the memories
   a_bad_skips_update : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bad) |=> (state_ff == ST_EMIT))
      else $error("rejected request entered the update path");

   // voltage data is only folded in for reads issued by the scan
   a_scan_reads_only : assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("voltage compare without a scan read");

   // no memory write while a result waits to leave
   a_no_write_in_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!pair_we && !volt_we))
      else $error("memory write during result hand-off");

endmodule
